/* rtl/core/cfd_pkg.sv */
package cfd_pkg;

  // Header geometry
  localparam int unsigned HDR_LEN = 12;
  localparam int unsigned HDR_CNT_W = 4;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_MAGIC   = 2'd0;
  localparam logic [1:0] ERR_VERSION = 2'd1;
  localparam logic [1:0] ERR_LENGTH  = 2'd2;
  localparam logic [1:0] ERR_FLAGS   = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef struct packed {
    logic [15:0] frame_magic;
    logic [7:0]  frame_version;
    logic [15:0] max_payload;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  msg_type;
    logic [31:0] seq;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;
    logic        last;
    logic [1:0]  error_code;
    logic        fatal;
  } result_t;

endpackage

/* rtl/core/cfd_if.sv */
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] rx_byte;

  modport source (output valid, output restart, output rx_byte, input ready);
  modport sink (input valid, input restart, input rx_byte, output ready);
endinterface

interface cfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  msg_type;
  logic [31:0] seq;
  logic [15:0] payload_len;
  logic [7:0]  data_byte;
  logic        last;
  logic [1:0]  error_code;
  logic        fatal;

  modport source (output valid, output kind, output msg_type, output seq,
                  output payload_len, output data_byte, output last,
                  output error_code, output fatal, input ready);
  modport sink (input valid, input kind, input msg_type, input seq,
                input payload_len, input data_byte, input last,
                input error_code, input fatal, output ready);
endinterface

interface cfd_cfg_if
  import cfd_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/cfd_parser.sv */
module cfd_parser
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       acc,
  input  logic       restart,
  input  logic [7:0] rx_byte,
  input  cfg_regs_t  cfg,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [1:0] MODE_COLLECT = 2'd0;
  localparam logic [1:0] MODE_PASS    = 2'd1;
  localparam logic [1:0] MODE_SKIP    = 2'd2;
  localparam logic [1:0] MODE_DEAD    = 2'd3;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_LEN - 1);

  logic [7:0]           header_store [HDR_LEN];
  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic [1:0]           parse_mode, parse_mode_next;
  logic [15:0]          bytes_left, bytes_left_next;

  logic [15:0] left_dec;
  logic [15:0] hdr_magic;
  logic [15:0] hdr_len;
  logic [15:0] hdr_flags;

  // Header fields; the final flags byte is the one arriving now
  assign hdr_magic = {header_store[1], header_store[0]};
  assign hdr_len   = {header_store[9], header_store[8]};
  assign hdr_flags = {rx_byte, header_store[10]};
  assign left_dec  = bytes_left - 16'd1;

  // Step the parser for one request
  always_comb begin
    header_count_next = header_count;
    parse_mode_next   = parse_mode;
    bytes_left_next   = bytes_left;
    res_valid         = 1'b0;
    res.kind          = KIND_HEADER;
    res.msg_type      = header_store[3];
    res.seq           = {header_store[7], header_store[6], header_store[5], header_store[4]};
    res.payload_len   = hdr_len;
    res.data_byte     = 8'd0;
    res.last          = 1'b0;
    res.error_code    = ERR_MAGIC;
    res.fatal         = 1'b0;
    if (restart) begin
      header_count_next = '0;
      parse_mode_next   = MODE_COLLECT;
      bytes_left_next   = 16'd0;
    end else begin
      unique case (parse_mode)
        MODE_PASS: begin
          bytes_left_next = left_dec;
          res_valid       = 1'b1;
          res.kind        = KIND_PAYLOAD;
          res.data_byte   = rx_byte;
          res.last        = (left_dec == 16'd0);
          if (left_dec == 16'd0) parse_mode_next = MODE_COLLECT;
        end
        MODE_SKIP: begin
          bytes_left_next = left_dec;
          if (left_dec == 16'd0) parse_mode_next = MODE_COLLECT;
        end
        MODE_DEAD: begin
        end
        MODE_COLLECT: begin
          if (header_count != HDR_LAST) begin
            header_count_next = header_count + HDR_CNT_W'(1);
          end else begin
            header_count_next = '0;
            res_valid         = 1'b1;
            priority if (hdr_magic != cfg.frame_magic) begin
              parse_mode_next = MODE_DEAD;
              res.kind        = KIND_ERROR;
              res.error_code  = ERR_MAGIC;
              res.fatal       = 1'b1;
            end else if (header_store[2] != cfg.frame_version) begin
              bytes_left_next = hdr_len;
              parse_mode_next = (hdr_len != 16'd0) ? MODE_SKIP : MODE_COLLECT;
              res.kind        = KIND_ERROR;
              res.error_code  = ERR_VERSION;
            end else if (hdr_len > cfg.max_payload) begin
              parse_mode_next = MODE_DEAD;
              res.kind        = KIND_ERROR;
              res.error_code  = ERR_LENGTH;
              res.fatal       = 1'b1;
            end else if (hdr_flags != 16'd0) begin
              bytes_left_next = hdr_len;
              parse_mode_next = (hdr_len != 16'd0) ? MODE_SKIP : MODE_COLLECT;
              res.kind        = KIND_ERROR;
              res.error_code  = ERR_FLAGS;
            end else begin
              bytes_left_next = hdr_len;
              parse_mode_next = (hdr_len != 16'd0) ? MODE_PASS : MODE_COLLECT;
              res.kind        = KIND_HEADER;
              res.last        = (hdr_len == 16'd0);
            end
          end
        end
      endcase
    end
  end

  // Advance control state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      parse_mode   <= MODE_COLLECT;
      bytes_left   <= 16'd0;
    end else if (acc) begin
      header_count <= header_count_next;
      parse_mode   <= parse_mode_next;
      bytes_left   <= bytes_left_next;
    end
  end

  // Capture header bytes while collecting
  always_ff @(posedge clk) begin
    if (acc && !restart && parse_mode == MODE_COLLECT) begin
      header_store[header_count] <= rx_byte;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    header_count <= HDR_LAST)
    else $error("header count out of range");

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (parse_mode == MODE_PASS || parse_mode == MODE_SKIP) |-> bytes_left != 16'd0)
    else $error("payload mode with no bytes left");

  a_dead_sticky: assert property (@(posedge clk) disable iff (rst)
    (acc && !restart && parse_mode == MODE_DEAD) |=> parse_mode == MODE_DEAD)
    else $error("dead parser left without restart");

endmodule

/* rtl/core/cfd_out_buf.sv */
module cfd_out_buf
  import cfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    pop_valid,
  input  logic    pop,
  output result_t pop_data
);

  result_t     mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  // Hold results until the downstream side takes them
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("result pushed into full buffer");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("result popped from empty buffer");

endmodule

/* rtl/core/control_frame_deframer.sv */
// Channel  Role   Payload                                   Request taken when
// din      sink   restart, rx_byte                          din.valid && din.ready
// dout     source kind, msg_type, seq, payload_len,         dout.valid && dout.ready
//                 data_byte, last, error_code, fatal
// cfg      sink   index, data                               cfg.valid && cfg.ready
//
// One input byte per cycle while din.ready is high; the parser step is a single
// pass from the parser state registers into a two-entry result buffer.
// Results are registered in the result buffer and drive dout from there.
// din.ready drops only while both result buffer entries wait on dout.
// Reset clears the parser and loads the register defaults; cfg is always ready.
module control_frame_deframer
  import cfd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  cfd_in_if.sink    din,
  cfd_out_if.source dout,
  cfd_cfg_if.sink   cfg
);

  cfg_regs_t cfg_regs;
  logic      buf_full;
  logic      in_acc;
  logic      res_valid;
  result_t   res;
  result_t   out_data;

  assign din.ready = ~buf_full;
  assign in_acc    = din.valid & din.ready;
  assign cfg.ready = 1'b1;

  // Load configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.frame_magic   <= 16'd0;
      cfg_regs.frame_version <= 8'd1;
      cfg_regs.max_payload   <= 16'd512;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MAGIC:   cfg_regs.frame_magic   <= cfg.data;
        REG_VERSION: cfg_regs.frame_version <= cfg.data[7:0];
        REG_MAX_LEN: cfg_regs.max_payload   <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  cfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .acc       (in_acc),
    .restart   (din.restart),
    .rx_byte   (din.rx_byte),
    .cfg       (cfg_regs),
    .res_valid (res_valid),
    .res       (res)
  );

  cfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_acc & res_valid),
    .push_data (res),
    .full      (buf_full),
    .pop_valid (dout.valid),
    .pop       (dout.valid & dout.ready),
    .pop_data  (out_data)
  );

  // Drive the result channel fields
  assign dout.kind        = out_data.kind;
  assign dout.msg_type    = out_data.msg_type;
  assign dout.seq         = out_data.seq;
  assign dout.payload_len = out_data.payload_len;
  assign dout.data_byte   = out_data.data_byte;
  assign dout.last        = out_data.last;
  assign dout.error_code  = out_data.error_code;
  assign dout.fatal       = out_data.fatal;

endmodule
